// ===== rtl/arm_forward_kinematics_7dof_top_macros.svh =====
// Assertion macros shared by the forward kinematics RTL.
`ifndef ARM_FORWARD_KINEMATICS_7DOF_TOP_MACROS_SVH
`define ARM_FORWARD_KINEMATICS_7DOF_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ARMFK_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ARMFK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ARMFK_ASSERT(label, clk, rst, ante, cons, msg)
`define ARMFK_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/armfk_pkg.sv =====
// Types, constants and rounding helpers of the forward kinematics pipeline.
package armfk_pkg;

  localparam int NUM_JOINTS = 7;
  localparam int FRAC_BITS  = 16;
  localparam int ANG_BITS   = 28;
  localparam int DIV_SHIFT  = 33;
  localparam int LINK_IDX_W = $clog2(NUM_JOINTS);

  localparam int COS_TERMS = 6;
  localparam int SIN_TERMS = 5;
  localparam int STEP_LAT  = 4;
  localparam int X_DLY     = 2 + STEP_LAT * SIN_TERMS;
  localparam int FLIP_DLY  = 2 + STEP_LAT * COS_TERMS;
  localparam int SIN_PAD   = STEP_LAT * (COS_TERMS - SIN_TERMS) - 2;
  localparam int X2_DLY    = STEP_LAT * (COS_TERMS - 1);
  localparam int TRIG_LAT  = 5 + STEP_LAT * COS_TERMS;
  localparam int LINK_LAT  = 2;

  typedef logic signed [15:0] angle_t;
  typedef logic signed [31:0] ang_t;
  typedef logic signed [17:0] trig_t;
  typedef logic signed [19:0] rot_t;
  typedef logic signed [23:0] pos_t;
  typedef logic signed [17:0] out_t;
  typedef logic signed [16:0] dist_t;
  typedef logic signed [39:0] prod_t;

  typedef rot_t rot_mat_t [3][3];
  typedef pos_t pos_vec_t [3];
  typedef out_t out_vec_t [3];
  typedef out_t out_mat_t [3][3];

  localparam ang_t ANG_ONE     = 32'sd268435456;
  localparam ang_t ANG_PI      = 32'sd843314857;
  localparam ang_t ANG_HALF_PI = 32'sd421657428;
  localparam ang_t ANG_TWO_PI  = 32'sd1686629713;

  localparam logic [7:0] COS_DIV [COS_TERMS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [7:0] SIN_DIV [SIN_TERMS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [32:0] COS_RECIP [COS_TERMS] = '{
    33'((64'd1 << DIV_SHIFT) / 132), 33'((64'd1 << DIV_SHIFT) / 90),
    33'((64'd1 << DIV_SHIFT) / 56),  33'((64'd1 << DIV_SHIFT) / 30),
    33'((64'd1 << DIV_SHIFT) / 12),  33'((64'd1 << DIV_SHIFT) / 2)};
  localparam logic [32:0] SIN_RECIP [SIN_TERMS] = '{
    33'((64'd1 << DIV_SHIFT) / 110), 33'((64'd1 << DIV_SHIFT) / 72),
    33'((64'd1 << DIV_SHIFT) / 42),  33'((64'd1 << DIV_SHIFT) / 20),
    33'((64'd1 << DIV_SHIFT) / 6)};

  // cos(pi/4) taken from Q.30 to Q.16 with rounding
  localparam rot_t C45 = rot_t'((64'd759250125 + 64'd8192) >> 14);
  localparam rot_t ROT_UNIT = rot_t'(1 << FRAC_BITS);

  // link offsets d in Q.16 metres (rounded from micrometres)
  localparam dist_t LINK_DQ [NUM_JOINTS] = '{
    17'sd18665, -17'sd773, 17'sd27578, -17'sd839, 17'sd20598, 17'sd0, 17'sd10971};
  // twist sin(alpha) = -1 on these links, +1 on the others but the last
  localparam logic [NUM_JOINTS-1:0] LINK_TW_NEG = 7'b0010101;
  // last link: alpha = 0
  localparam logic [NUM_JOINTS-1:0] LINK_LAST   = 7'b1000000;

  localparam logic [15:0] OFFSET_RESET = 16'd3604;

  localparam logic signed [63:0] POS_MAX = (64'sd2 <<< FRAC_BITS) - 64'sd1;
  localparam logic signed [63:0] POS_MIN = -(64'sd2 <<< FRAC_BITS);
  localparam logic signed [63:0] ROT_MAX = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] ROT_MIN = -(64'sd1 <<< FRAC_BITS);

  // shift right with rounding half away from zero
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int s);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

endpackage

// ===== rtl/armfk_if.sv =====
// Valid/ready channel interfaces for joint vectors and camera poses.
interface armfk_joint_if;
  import armfk_pkg::*;
  logic   valid;
  logic   ready;
  angle_t joint_angle_1;
  angle_t joint_angle_2;
  angle_t joint_angle_3;
  angle_t joint_angle_4;
  angle_t joint_angle_5;
  angle_t joint_angle_6;
  angle_t joint_angle_7;
  modport source (output valid, joint_angle_1, joint_angle_2, joint_angle_3,
                  joint_angle_4, joint_angle_5, joint_angle_6, joint_angle_7,
                  input ready);
  modport sink (input valid, joint_angle_1, joint_angle_2, joint_angle_3,
                joint_angle_4, joint_angle_5, joint_angle_6, joint_angle_7,
                output ready);
endinterface

interface armfk_pose_if;
  import armfk_pkg::*;
  logic valid;
  logic ready;
  out_t cam_pos_x;
  out_t cam_pos_y;
  out_t cam_pos_z;
  out_t rot_r0c0;
  out_t rot_r0c1;
  out_t rot_r0c2;
  out_t rot_r1c0;
  out_t rot_r1c1;
  out_t rot_r1c2;
  out_t rot_r2c0;
  out_t rot_r2c1;
  out_t rot_r2c2;
  modport source (output valid, cam_pos_x, cam_pos_y, cam_pos_z,
                  rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1, rot_r1c2,
                  rot_r2c0, rot_r2c1, rot_r2c2, input ready);
  modport sink (input valid, cam_pos_x, cam_pos_y, cam_pos_z,
                rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1, rot_r1c2,
                rot_r2c0, rot_r2c1, rot_r2c2, output ready);
endinterface

// ===== rtl/arm_forward_kinematics_7dof_top.sv =====
// Top level of the seven-joint forward kinematics pipeline with camera mount.
//
// Usage:
//   joint : sink channel, one item = seven joint angles (Q3.13 rad). An item
//           is taken at a clock edge with joint.valid and joint.ready high.
//   pose  : source channel, one item = camera position (Q2.16 m, saturated
//           at +-2 m) and camera rotation matrix (Q2.16, clamped to +-1), row major.
//   cfg_we / cfg_wdata : write of camera_offset_y (Q0.16 m), taken at any
//           edge with cfg_we high; write it only while the pipeline is empty.
// Path: from accept to pose.valid through the sine/cosine series, the seven
//   links and the camera mount stage, all registered.
// Throughput: one item per cycle. The whole pipeline moves on one enable,
//   so the rate is set by the output handshake alone.
// Stall: while pose.valid is high and pose.ready low every stage holds and
//   joint.ready drops; nothing is lost or repeated. Bubbles already in the
//   pipe hold their place during the stall and are not squeezed out.
// Reset: rst (synchronous, active high) clears all valid bits and loads
//   camera_offset_y with 3604 (about 0.055 m).
`include "arm_forward_kinematics_7dof_top_macros.svh"
module arm_forward_kinematics_7dof_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  armfk_joint_if.sink       joint,
  armfk_pose_if.source      pose
);
  import armfk_pkg::*;

  logic                   en;
  logic [15:0]            offset;
  angle_t                 ang_in [NUM_JOINTS];
  angle_t                 ang_d [NUM_JOINTS];
  trig_t                  sn [NUM_JOINTS];
  trig_t                  cs [NUM_JOINTS];
  logic [TRIG_LAT-1:0]    vtrig;
  rot_mat_t               rm [NUM_JOINTS+1];
  pos_vec_t               pm [NUM_JOINTS+1];
  logic [NUM_JOINTS:0]    lv;
  out_vec_t               cam_pos;
  out_mat_t               rot;

  // advance everything unless a result is held at the output
  assign en          = !pose.valid || pose.ready;
  assign joint.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= OFFSET_RESET;
    end else if (cfg_we) begin
      offset <= cfg_wdata;
    end
  end

  always_comb begin
    ang_in[0] = joint.joint_angle_1;
    ang_in[1] = joint.joint_angle_2;
    ang_in[2] = joint.joint_angle_3;
    ang_in[3] = joint.joint_angle_4;
    ang_in[4] = joint.joint_angle_5;
    ang_in[5] = joint.joint_angle_6;
    ang_in[6] = joint.joint_angle_7;
  end

  // valid bits alongside the sine/cosine series
  always_ff @(posedge clk) begin
    if (rst) begin
      vtrig <= '0;
    end else if (en) begin
      vtrig <= {vtrig[TRIG_LAT-2:0], joint.valid};
    end
  end

  // delay joint i through a register line matching the links before it so its
  // sine and cosine arrive together with the frame of the link before it
  for (genvar i = 0; i < NUM_JOINTS; i++) begin : g_joint
    if (i == 0) begin : g_direct
      assign ang_d[i] = ang_in[i];
    end else begin : g_delay
      angle_t line [LINK_LAT*i];
      always_ff @(posedge clk) begin
        if (en) begin
          line[0] <= ang_in[i];
          for (int k = 1; k < LINK_LAT*i; k++) line[k] <= line[k-1];
        end
      end
      assign ang_d[i] = line[LINK_LAT*i-1];
    end

    // odd-numbered joints (1, 3, 5, 7) turn the other way
    armfk_sincos u_sincos (
      .clk   (clk),
      .en    (en),
      .neg   ((i % 2) == 0),
      .a     (ang_d[i]),
      .sin_q (sn[i]),
      .cos_q (cs[i])
    );
  end

  // base frame: -pi/4 about z, at the origin
  always_comb begin
    rm[0][0][0] = C45;
    rm[0][0][1] = C45;
    rm[0][0][2] = '0;
    rm[0][1][0] = -C45;
    rm[0][1][1] = C45;
    rm[0][1][2] = '0;
    rm[0][2][0] = '0;
    rm[0][2][1] = '0;
    rm[0][2][2] = ROT_UNIT;
    for (int r = 0; r < 3; r++) pm[0][r] = '0;
  end
  assign lv[0] = vtrig[TRIG_LAT-1];

  for (genvar i = 0; i < NUM_JOINTS; i++) begin : g_link
    armfk_link u_link (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .idx       (LINK_IDX_W'(i)),
      .valid_in  (lv[i]),
      .r_in      (rm[i]),
      .p_in      (pm[i]),
      .s         (sn[i]),
      .c         (cs[i]),
      .valid_out (lv[i+1]),
      .r_out     (rm[i+1]),
      .p_out     (pm[i+1])
    );
  end

  armfk_camera u_camera (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .off       (offset),
    .valid_in  (lv[NUM_JOINTS]),
    .r_in      (rm[NUM_JOINTS]),
    .p_in      (pm[NUM_JOINTS]),
    .valid_out (pose.valid),
    .cam_pos   (cam_pos),
    .rot       (rot)
  );

  assign pose.cam_pos_x = cam_pos[0];
  assign pose.cam_pos_y = cam_pos[1];
  assign pose.cam_pos_z = cam_pos[2];
  assign pose.rot_r0c0  = rot[0][0];
  assign pose.rot_r0c1  = rot[0][1];
  assign pose.rot_r0c2  = rot[0][2];
  assign pose.rot_r1c0  = rot[1][0];
  assign pose.rot_r1c1  = rot[1][1];
  assign pose.rot_r1c2  = rot[1][2];
  assign pose.rot_r2c0  = rot[2][0];
  assign pose.rot_r2c1  = rot[2][1];
  assign pose.rot_r2c2  = rot[2][2];

  `ARMFK_ASSERT_NEXT(a_stall_freeze, clk, rst, !en, $stable(vtrig), "series valid moved in stall")
  `ARMFK_ASSERT_NEXT(a_accept_enters, clk, rst, joint.valid && joint.ready, vtrig[0], "accepted item not tracked")

endmodule

// ===== rtl/armfk_poly_step.sv =====
// One series term t_out = 1 - round(x2 * t_in) / k, four register stages.
module armfk_poly_step (
  input  logic              clk,
  input  logic              en,
  input  logic [7:0]        k,
  input  logic [32:0]       m,
  input  armfk_pkg::ang_t   x2_in,
  input  armfk_pkg::ang_t   t_in,
  output armfk_pkg::ang_t   t_out
);
  import armfk_pkg::*;

  logic signed [63:0] prod1;
  logic [63:0]        pabs;
  logic [30:0]        mag2;
  logic               neg2;
  logic [63:0]        qm3;
  logic [30:0]        mag3;
  logic               neg3;
  logic [30:0]        q0;
  logic [31:0]        rem;
  logic [30:0]        q;
  ang_t               sq;

  always_comb begin
    pabs = prod1[63] ? 64'(-prod1) : 64'(prod1);
    q0   = 31'(qm3 >> DIV_SHIFT);
    rem  = 32'(mag3) - 32'(q0) * 32'(k);
    q    = (rem >= 32'(k)) ? q0 + 31'd1 : q0;
    sq   = ang_t'({1'b0, q});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= 64'(x2_in) * 64'(t_in);
      mag2  <= 31'((pabs + (64'd1 << (ANG_BITS - 1))) >> ANG_BITS);
      neg2  <= prod1[63];
      qm3   <= 64'(mag2) * 64'(m);
      mag3  <= mag2;
      neg3  <= neg2;
      // truncating quotient, corrected once from the reciprocal estimate
      t_out <= ANG_ONE - (neg3 ? -sq : sq);
    end
  end

endmodule

// ===== rtl/armfk_sincos.sv =====
// Sine and cosine of one joint angle, Q.28 series rounded to Q.16.
module armfk_sincos (
  input  logic              clk,
  input  logic              en,
  input  logic              neg,
  input  armfk_pkg::angle_t a,
  output armfk_pkg::trig_t  sin_q,
  output armfk_pkg::trig_t  cos_q
);
  import armfk_pkg::*;

  ang_t               ang_w;
  ang_t               ang_n;
  ang_t               x1_next;
  ang_t               x1;
  ang_t               xr_next;
  logic               flip_next;
  ang_t               xr;
  logic               flip;
  logic signed [63:0] sq3;
  ang_t               x2v;
  ang_t               x2_dly [X2_DLY];
  ang_t               x2_tap [COS_TERMS];
  ang_t               cos_t [COS_TERMS+1];
  ang_t               sin_t [SIN_TERMS+1];
  ang_t               x_dly [X_DLY];
  logic [FLIP_DLY-1:0] flip_dly;
  logic signed [63:0] sp;
  ang_t               s28;
  ang_t               s_dly [SIN_PAD];
  ang_t               c_sgn;

  always_comb begin
    ang_w = ang_t'(a) <<< (ANG_BITS - 13);
    ang_n = neg ? -ang_w : ang_w;
    if (ang_n > ANG_PI) begin
      x1_next = ang_n - ANG_TWO_PI;
    end else if (ang_n < -ANG_PI) begin
      x1_next = ang_n + ANG_TWO_PI;
    end else begin
      x1_next = ang_n;
    end
    // reflect into +-pi/2, cosine changes sign
    if (x1 > ANG_HALF_PI) begin
      xr_next   = ANG_PI - x1;
      flip_next = 1'b1;
    end else if (x1 < -ANG_HALF_PI) begin
      xr_next   = -ANG_PI - x1;
      flip_next = 1'b1;
    end else begin
      xr_next   = x1;
      flip_next = 1'b0;
    end
    c_sgn = flip_dly[FLIP_DLY-1] ? -cos_t[COS_TERMS] : cos_t[COS_TERMS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= x1_next;
      xr   <= xr_next;
      flip <= flip_next;
      sq3  <= 64'(xr) * 64'(xr);
      x2v  <= ang_t'((sq3 + (64'sd1 <<< (ANG_BITS - 1))) >>> ANG_BITS);
      x2_dly[0] <= x2v;
      for (int i = 1; i < X2_DLY; i++) x2_dly[i] <= x2_dly[i-1];
      x_dly[0] <= xr;
      for (int i = 1; i < X_DLY; i++) x_dly[i] <= x_dly[i-1];
      flip_dly <= {flip_dly[FLIP_DLY-2:0], flip};
      sp  <= 64'(x_dly[X_DLY-1]) * 64'(sin_t[SIN_TERMS]);
      s28 <= ang_t'(round_shift(sp, ANG_BITS));
      s_dly[0] <= s28;
      for (int i = 1; i < SIN_PAD; i++) s_dly[i] <= s_dly[i-1];
      sin_q <= trig_t'(round_shift(64'(s_dly[SIN_PAD-1]), ANG_BITS - FRAC_BITS));
      cos_q <= trig_t'(round_shift(64'(c_sgn), ANG_BITS - FRAC_BITS));
    end
  end

  assign cos_t[0] = ANG_ONE;
  assign sin_t[0] = ANG_ONE;

  for (genvar g = 0; g < COS_TERMS; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign x2_tap[g] = x2v;
    end else begin : g_rest
      assign x2_tap[g] = x2_dly[STEP_LAT*g-1];
    end
  end

  for (genvar g = 0; g < COS_TERMS; g++) begin : g_cos
    armfk_poly_step u_step (
      .clk   (clk),
      .en    (en),
      .k     (COS_DIV[g]),
      .m     (COS_RECIP[g]),
      .x2_in (x2_tap[g]),
      .t_in  (cos_t[g]),
      .t_out (cos_t[g+1])
    );
  end

  for (genvar g = 0; g < SIN_TERMS; g++) begin : g_sin
    armfk_poly_step u_step (
      .clk   (clk),
      .en    (en),
      .k     (SIN_DIV[g]),
      .m     (SIN_RECIP[g]),
      .x2_in (x2_tap[g]),
      .t_in  (sin_t[g]),
      .t_out (sin_t[g+1])
    );
  end

endmodule

// ===== rtl/armfk_link.sv =====
// One Denavit-Hartenberg link: rotation product and position update.
`include "arm_forward_kinematics_7dof_top_macros.svh"
module armfk_link (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic [armfk_pkg::LINK_IDX_W-1:0]     idx,
  input  logic                                 valid_in,
  input  armfk_pkg::rot_mat_t                  r_in,
  input  armfk_pkg::pos_vec_t                  p_in,
  input  armfk_pkg::trig_t                     s,
  input  armfk_pkg::trig_t                     c,
  output logic                                 valid_out,
  output armfk_pkg::rot_mat_t                  r_out,
  output armfk_pkg::pos_vec_t                  p_out
);
  import armfk_pkg::*;

  dist_t dq;
  logic  twneg;
  logic  last;
  logic  v1;
  prod_t pa [3];
  prod_t pb [3];
  prod_t pe [3];
  prod_t pf [3];
  prod_t pd [3];
  rot_t  r2_1 [3];
  pos_t  p1 [3];
  rot_t  n0 [3];
  rot_t  n21 [3];

  always_comb begin
    dq    = LINK_DQ[idx];
    twneg = LINK_TW_NEG[idx];
    last  = LINK_LAST[idx];
    for (int r = 0; r < 3; r++) begin
      n0[r]  = rot_t'(round_shift(64'(pa[r] + pb[r]), FRAC_BITS));
      n21[r] = rot_t'(round_shift(64'(pf[r] - pe[r]), FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      v1        <= valid_in;
      valid_out <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        pa[r]   <= 40'(r_in[r][0]) * 40'(c);
        pb[r]   <= 40'(r_in[r][1]) * 40'(s);
        pe[r]   <= 40'(r_in[r][0]) * 40'(s);
        pf[r]   <= 40'(r_in[r][1]) * 40'(c);
        pd[r]   <= 40'(r_in[r][2]) * 40'(dq);
        r2_1[r] <= r_in[r][2];
        p1[r]   <= p_in[r];
      end
      for (int r = 0; r < 3; r++) begin
        r_out[r][0] <= n0[r];
        if (last) begin
          r_out[r][1] <= n21[r];
          r_out[r][2] <= r2_1[r];
        end else if (twneg) begin
          r_out[r][1] <= -r2_1[r];
          r_out[r][2] <= n21[r];
        end else begin
          r_out[r][1] <= r2_1[r];
          r_out[r][2] <= -n21[r];
        end
        p_out[r] <= p1[r] + pos_t'(round_shift(64'(pd[r]), FRAC_BITS));
      end
    end
  end

  `ARMFK_ASSERT_NEXT(a_twist_col, clk, rst, en && v1 && !last, r_out[0][1] == (twneg ? -$past(r2_1[0]) : $past(r2_1[0])), "twisting link lost z column")
  `ARMFK_ASSERT_NEXT(a_link_hold, clk, rst, !en, $stable(valid_out) && $stable(v1), "link valid moved in stall")

endmodule

// ===== rtl/armfk_camera.sv =====
// Camera mount: offset along end-effector y, flip of x and y axes, saturation.
`include "arm_forward_kinematics_7dof_top_macros.svh"
module armfk_camera (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [15:0]         off,
  input  logic                valid_in,
  input  armfk_pkg::rot_mat_t r_in,
  input  armfk_pkg::pos_vec_t p_in,
  output logic                valid_out,
  output armfk_pkg::out_vec_t cam_pos,
  output armfk_pkg::out_mat_t rot
);
  import armfk_pkg::*;

  logic               v1;
  prod_t              pr [3];
  pos_t               p1 [3];
  rot_mat_t           rk1;
  logic signed [63:0] psum [3];
  logic signed [63:0] rv [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      psum[r] = 64'(p1[r]) + round_shift(64'(pr[r]), FRAC_BITS);
      for (int k = 0; k < 3; k++) begin
        rv[r][k] = (k < 2) ? -64'(rk1[r][k]) : 64'(rk1[r][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      v1        <= valid_in;
      valid_out <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        pr[r] <= 40'(r_in[r][1]) * 40'($signed({1'b0, off}));
        p1[r] <= p_in[r];
      end
      rk1 <= r_in;
      for (int r = 0; r < 3; r++) begin
        cam_pos[r] <= out_t'(clamp(psum[r], POS_MIN, POS_MAX));
        for (int k = 0; k < 3; k++) begin
          rot[r][k] <= out_t'(clamp(rv[r][k], ROT_MIN, ROT_MAX));
        end
      end
    end
  end

  `ARMFK_ASSERT(a_rot_range, clk, rst, valid_out, 64'(rot[2][2]) <= ROT_MAX && 64'(rot[2][2]) >= ROT_MIN && 64'(rot[0][0]) <= ROT_MAX && 64'(rot[0][0]) >= ROT_MIN, "rotation entry out of range")

endmodule

// ===== sim/tb_arm_forward_kinematics_7dof_top.sv =====
// Self-checking testbench of the seven-joint forward kinematics pipeline.
`timescale 1ns / 100ps
module tb_arm_forward_kinematics_7dof_top;
  import armfk_pkg::*;

  localparam int PIPE_LAT   = 45;
  localparam int IDLE_LIMIT = 5000;
  localparam int NUM_RAND   = 550;

  typedef struct {
    logic signed [17:0] f [12];
  } pose_t;

  // Fixed-point pose predictor with its own copy of the mount offset.
  class pose_scoreboard;
    pose_t       pending [$];
    logic [15:0] mount_off;
    int          errors;
    int          checked;

    function new();
      mount_off = OFFSET_RESET;
      errors    = 0;
      checked   = 0;
    endfunction

    static function longint rnd_shift(longint v, int s);
      longint m;
      m = v < 0 ? -v : v;
      m = (m + (longint'(1) << (s - 1))) >>> s;
      return v < 0 ? -m : m;
    endfunction

    static function void trig(longint x, output longint s_q, output longint c_q);
      longint angle_one, x2, t, s;
      longint sdiv [5];
      longint cdiv [6];
      bit flip;
      angle_one = longint'(1) << 28;
      sdiv = '{110, 72, 42, 20, 6};
      cdiv = '{132, 90, 56, 30, 12, 2};
      flip = 0;
      if (x > 421657428) begin
        x = 843314857 - x; flip = 1;
      end else if (x < -421657428) begin
        x = -843314857 - x; flip = 1;
      end
      x2 = rnd_shift(x * x, 28);
      t = angle_one;
      for (int i = 0; i < 5; i++) t = angle_one - rnd_shift(x2 * t, 28) / sdiv[i];
      s = rnd_shift(x * t, 28);
      t = angle_one;
      for (int i = 0; i < 6; i++) t = angle_one - rnd_shift(x2 * t, 28) / cdiv[i];
      if (flip) t = -t;
      s_q = rnd_shift(s, 12);
      c_q = rnd_shift(t, 12);
    endfunction

    function pose_t predict(angle_t q [7]);
      longint r [3][3];
      longint a [3][3];
      longint n [3][3];
      longint p [3];
      longint dq [7];
      int sa [7];
      int ca [7];
      longint one, c45, ang, st, ct, acc, v;
      pose_t res;
      one = 65536;
      dq = '{284800, -11800, 420800, -12800, 314300, 0, 167400};
      sa = '{-1, 1, -1, 1, -1, 1, 0};
      ca = '{0, 0, 0, 0, 0, 0, 1};
      c45 = rnd_shift(759250125, 14);
      r = '{'{c45, c45, 0}, '{-c45, c45, 0}, '{0, 0, one}};
      p = '{0, 0, 0};
      for (int i = 0; i < 7; i++) begin
        ang = longint'(q[i]) * 32768;
        if ((i & 1) == 0) ang = -ang;
        if (ang > 843314857) ang -= 1686629713;
        else if (ang < -843314857) ang += 1686629713;
        trig(ang, st, ct);
        a = '{'{ct, -st * ca[i], st * sa[i]}, '{st, ct * ca[i], -ct * sa[i]},
              '{0, sa[i] * one, ca[i] * one}};
        // round micrometres to Q.16 metres, half away from zero
        v = dq[i] * 65536;
        v = v < 0 ? -((-v + 500000) / 1000000) : (v + 500000) / 1000000;
        for (int j = 0; j < 3; j++) p[j] += rnd_shift(r[j][2] * v, 16);
        for (int j = 0; j < 3; j++)
          for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += r[j][k] * a[k][c];
            n[j][c] = rnd_shift(acc, 16);
          end
        r = n;
      end
      for (int j = 0; j < 3; j++) begin
        v = p[j] + rnd_shift(r[j][1] * longint'(mount_off), 16);
        v = v < -131072 ? -131072 : (v > 131071 ? 131071 : v);
        res.f[j] = 18'(v);
      end
      for (int j = 0; j < 3; j++)
        for (int c = 0; c < 3; c++) begin
          v = c < 2 ? -r[j][c] : r[j][c];
          v = v < -one ? -one : (v > one ? one : v);
          res.f[3 + 3 * j + c] = 18'(v);
        end
      return res;
    endfunction

    function void note_joints(angle_t q [7]);
      pending.push_back(predict(q));
    endfunction

    function void check_pose(pose_t got);
      string names [12];
      pose_t exp_pose;
      names = '{"cam_pos_x", "cam_pos_y", "cam_pos_z", "rot_r0c0", "rot_r0c1",
                "rot_r0c2", "rot_r1c0", "rot_r1c1", "rot_r1c2", "rot_r2c0",
                "rot_r2c1", "rot_r2c2"};
      checked++;
      if (pending.size() == 0) begin
        $error("pose item with no pending prediction");
        errors++;
        return;
      end
      exp_pose = pending.pop_front();
      for (int i = 0; i < 12; i++)
        if (got.f[i] !== exp_pose.f[i]) begin
          $error("%s mismatch: expected %0d, actual %0d", names[i], exp_pose.f[i], got.f[i]);
          errors++;
        end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  armfk_joint_if joint ();
  armfk_pose_if  pose ();

  arm_forward_kinematics_7dof_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .joint     (joint.sink),
    .pose      (pose.source)
  );

  pose_scoreboard sb = new();

  // Random gaps on both sides; quiet_mode turns them off for a stretch.
  bit quiet_mode;
  int accepted;
  int idle_cycles;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    joint.valid = 1'b0;
    {joint.joint_angle_1, joint.joint_angle_2, joint.joint_angle_3, joint.joint_angle_4,
     joint.joint_angle_5, joint.joint_angle_6, joint.joint_angle_7} = '0;
    pose.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Sample the result side at the edge; drive ready for the next cycle.
  always @(posedge clk) begin
    pose_t got;
    if (!rst) begin
      if (pose.valid && pose.ready) begin
        got.f = '{pose.cam_pos_x, pose.cam_pos_y, pose.cam_pos_z, pose.rot_r0c0,
                  pose.rot_r0c1, pose.rot_r0c2, pose.rot_r1c0, pose.rot_r1c1,
                  pose.rot_r1c2, pose.rot_r2c0, pose.rot_r2c1, pose.rot_r2c2};
        sb.check_pose(got);
      end
      pose.ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 16);
    end
  end

  // Watchdog: count cycles in which no item moves on either side.
  always @(posedge clk) begin
    if (rst || (joint.valid && joint.ready) || (pose.valid && pose.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Present one joint vector, hold it until taken, then maybe idle.
  task automatic send_joints(angle_t q [7]);
    joint.valid <= 1'b1;
    joint.joint_angle_1 <= q[0];
    joint.joint_angle_2 <= q[1];
    joint.joint_angle_3 <= q[2];
    joint.joint_angle_4 <= q[3];
    joint.joint_angle_5 <= q[4];
    joint.joint_angle_6 <= q[5];
    joint.joint_angle_7 <= q[6];
    do @(posedge clk); while (!joint.ready);
    sb.note_joints(q);
    accepted++;
    if (!quiet_mode) begin
      while ($urandom_range(99) < 16) begin
        joint.valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Drop valid and hold until every pending pose has come back.
  task automatic drain();
    joint.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Write the mount offset with the pipe empty.
  task automatic write_offset(logic [15:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.mount_off = value;
  endtask

  task automatic send_random(int count);
    angle_t q [7];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 7; i++) begin
        case ($urandom_range(9))
          0: q[i] = 16'sh7FFF;
          1: q[i] = 16'sh8000;
          // near +-pi, where the wrap and reflection kick in
          2: q[i] = 16'(($urandom_range(1) ? 25736 : -25736) + $signed($urandom_range(400)) - 200);
          default: q[i] = angle_t'($urandom_range(16'hFFFF));
        endcase
      end
      send_joints(q);
    end
  endtask

  initial begin
    angle_t q [7];
    int dir_count;
    accepted = 0;
    quiet_mode = 1'b0;
    @(negedge rst);
    @(posedge clk);

    // Directed: zero pose, extremes, +-pi, +-pi/2, alternating signs, a mixed vector and each joint alone at pi/2.
    q = '{default: 16'sd0};                 send_joints(q);
    q = '{default: 16'sh7FFF};              send_joints(q);
    q = '{default: 16'sh8000};              send_joints(q);
    q = '{default: 16'sd25736};             send_joints(q);
    q = '{default: -16'sd25736};            send_joints(q);
    q = '{default: 16'sd25737};             send_joints(q);
    q = '{default: -16'sd25737};            send_joints(q);
    q = '{default: 16'sd12868};             send_joints(q);
    q = '{default: -16'sd12868};            send_joints(q);
    q = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
    send_joints(q);
    q = '{16'sh5555, -16'sh5556, 16'sh2AAA, -16'sh2AAB, 16'sd1, -16'sd1, 16'sd8192};
    send_joints(q);
    for (int i = 0; i < 7; i++) begin
      q = '{default: 16'sd0};
      q[i] = 16'sd12868;
      send_joints(q);
    end
    dir_count = accepted;

    // Pause with the pipe fully drained, then reach both offset extremes.
    write_offset(16'd0);
    q = '{default: 16'sd0};                 send_joints(q);
    q = '{default: 16'sd6000};              send_joints(q);
    write_offset(16'hFFFF);
    q = '{default: 16'sd0};                 send_joints(q);
    q = '{default: -16'sd6000};             send_joints(q);
    send_random(60);

    // A stretch with no idling on either side.
    write_offset(16'h8000);
    quiet_mode = 1'b1;
    send_random(150);
    quiet_mode = 1'b0;

    write_offset(16'($urandom_range(16'hFFFF)));
    send_random(170);
    write_offset(OFFSET_RESET);
    send_random(NUM_RAND - 380);

    drain();
    repeat (PIPE_LAT + 10) @(posedge clk);
    $display("Covered %0d joint vectors (%0d directed) and %0d poses checked,",
             accepted, dir_count, sb.checked);
    $display("across mount offsets 0, max, mid, random and reset, with random stalls.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
